@@ design/muc_pkg.sv @@
`timescale 1ns / 1ps

package muc_pkg;

	// Depth of the request queue between front and back.
	localparam int QDepth = 4;
	localparam int QAw    = $clog2(QDepth);

	typedef enum logic {
		DIR_ENCODE = 1'b0,
		DIR_DECODE = 1'b1
	} dir_t;

	// Lead byte classes by the top three bits.
	localparam logic [2:0] LEAD_TWO   = 3'b110;
	localparam logic [2:0] LEAD_THREE = 3'b111;

	localparam logic [7:0] NUL_B0  = 8'hc0;
	localparam logic [7:0] CONT_HI = 8'h80;
	localparam logic [7:0] LEAD2_HI = 8'hc0;
	localparam logic [7:0] LEAD3_HI = 8'he0;

	// One request from front to back: one to three results.
	typedef struct packed {
		dir_t        dir;
		logic [1:0]  cnt;    // results to emit, 1..3
		logic [23:0] data;   // encode: byte i at [8*i +: 8]; decode: unit in [15:0]
		logic        eos;
		logic        trunc;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} q_head_t;

endpackage

@@ design/muc_front.sv @@
`timescale 1ns / 1ps

module muc_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_wdata,
	input  logic              accept,
	input  logic [15:0]       in_code_unit,
	input  logic [7:0]        in_byte,
	input  logic              end_of_string,
	output logic              push,
	output muc_pkg::cmd_t     push_cmd
);
	import muc_pkg::*;

	dir_t        dir_q;
	logic [1:0]  pend_q;
	logic [15:0] part_q;

	logic [1:0]  pend_d;
	logic [15:0] part_d;
	logic        emit;
	logic [15:0] unit;
	logic        trunc;
	cmd_t        enc_cmd;
	logic [15:0] c;

	// Encode: build one to three bytes.
	always_comb begin
		c = in_code_unit;
		enc_cmd = '0;
		enc_cmd.dir = DIR_ENCODE;
		enc_cmd.eos = end_of_string;
		if (c == 16'd0) begin
			enc_cmd.cnt = 2'd2;
			enc_cmd.data = {8'h00, CONT_HI, NUL_B0};
		end else if (c < 16'h0080) begin
			enc_cmd.cnt = 2'd1;
			enc_cmd.data = {16'h0000, c[7:0]};
		end else if (c < 16'h0800) begin
			enc_cmd.cnt = 2'd2;
			enc_cmd.data = {8'h00, CONT_HI | {2'b00, c[5:0]}, LEAD2_HI | {3'b000, c[10:6]}};
		end else begin
			enc_cmd.cnt = 2'd3;
			enc_cmd.data = {CONT_HI | {2'b00, c[5:0]}, CONT_HI | {2'b00, c[11:6]},
				LEAD3_HI | {4'b0000, c[15:12]}};
		end
	end

	// Decode: gather payload bits, emit on completion or cut-off.
	always_comb begin
		pend_d = pend_q;
		part_d = part_q;
		emit   = 1'b0;
		unit   = 16'd0;
		trunc  = 1'b0;
		if (pend_q == 2'd0) begin
			unique case (in_byte[7:5])
				LEAD_TWO: begin
					part_d = {11'd0, in_byte[4:0]};
					pend_d = 2'd1;
				end
				LEAD_THREE: begin
					part_d = {12'd0, in_byte[3:0]};
					pend_d = 2'd2;
				end
				default: begin
					unit = {9'd0, in_byte[6:0]};
					emit = 1'b1;
				end
			endcase
		end else begin
			part_d = {part_q[9:0], in_byte[5:0]};
			pend_d = pend_q - 2'd1;
			if (pend_d == 2'd0) begin
				unit   = part_d;
				part_d = 16'd0;
				emit   = 1'b1;
			end
		end
		if (!emit && end_of_string) begin
			// missing bytes count as zero payload
			unit   = (pend_d == 2'd1) ? {part_d[9:0], 6'd0} : {part_d[3:0], 12'd0};
			trunc  = 1'b1;
			pend_d = 2'd0;
			part_d = 16'd0;
		end
	end

	always_comb begin
		if (dir_q == DIR_ENCODE) begin
			push_cmd = enc_cmd;
			push     = accept;
		end else begin
			push_cmd       = '0;
			push_cmd.dir   = DIR_DECODE;
			push_cmd.cnt   = 2'd1;
			push_cmd.data  = {8'h00, unit};
			push_cmd.eos   = end_of_string | trunc;
			push_cmd.trunc = trunc;
			push           = accept && (emit || end_of_string);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q  <= DIR_ENCODE;
			pend_q <= 2'd0;
			part_q <= 16'd0;
		end else if (cfg_we) begin
			dir_q  <= dir_t'(cfg_wdata);
			pend_q <= 2'd0;
			part_q <= 16'd0;
		end else if (accept && dir_q == DIR_DECODE) begin
			pend_q <= pend_d;
			part_q <= part_d;
		end
	end

endmodule

@@ design/muc_queue.sv @@
`timescale 1ns / 1ps

module muc_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  muc_pkg::cmd_t     push_cmd,
	input  logic              pop,
	output logic              full,
	output muc_pkg::q_head_t  head
);
	import muc_pkg::*;

	cmd_t           mem_q [QDepth];
	logic [QAw-1:0] wr_q;
	logic [QAw-1:0] rd_q;
	logic [QAw:0]   cnt_q;

	assign full       = (cnt_q == (QAw+1)'(QDepth));
	assign head.valid = (cnt_q != '0);
	assign head.cmd   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

@@ design/muc_back.sv @@
`timescale 1ns / 1ps

module muc_back (
	input  logic              clk,
	input  logic              arst_n,
	input  muc_pkg::q_head_t  head,
	output logic              pop,
	input  logic              dst_stall,
	output logic              dst_valid,
	output logic [7:0]        out_byte,
	output logic [15:0]       out_code_unit,
	output logic              last_of_run,
	output logic              truncated,
	output logic              string_done
);
	import muc_pkg::*;

	logic        vld_q;
	logic [1:0]  idx_q;
	logic [7:0]  byte_q;
	logic [15:0] unit_q;
	logic        last_q;
	logic        trunc_q;
	logic        done_q;

	logic        load;
	logic        last;

	assign load = head.valid && (!vld_q || !dst_stall);
	assign last = (idx_q == head.cmd.cnt - 2'd1);
	assign pop  = load && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			idx_q <= 2'd0;
		end else begin
			if (load) begin
				vld_q <= 1'b1;
				idx_q <= last ? 2'd0 : idx_q + 2'd1;
			end else if (!dst_stall) begin
				vld_q <= 1'b0;
			end
		end
	end

	// Payload: one byte or one unit per result.
	always_ff @(posedge clk) begin
		if (load) begin
			if (head.cmd.dir == DIR_ENCODE) begin
				byte_q <= head.cmd.data[8*idx_q +: 8];
				unit_q <= 16'd0;
			end else begin
				byte_q <= 8'd0;
				unit_q <= head.cmd.data[15:0];
			end
			last_q  <= last;
			trunc_q <= head.cmd.trunc;
			done_q  <= last && head.cmd.eos;
		end
	end

	assign dst_valid     = vld_q;
	assign out_byte      = byte_q;
	assign out_code_unit = unit_q;
	assign last_of_run   = last_q;
	assign truncated     = trunc_q;
	assign string_done   = done_q;

endmodule

@@ design/modified_utf8_codec_top.sv @@
`timescale 1ns / 1ps

// Modified UTF-8 codec (Java style). cfg_wdata written with cfg_we selects the
// direction: 0 encodes 16-bit code units into one to three bytes (NUL becomes
// C0 80, surrogates are encoded alone), 1 decodes bytes back into code units.
// Writing the register also clears the decoder; write it only while the block
// is idle. Each request on the src channel gives zero or more results on the
// dst channel; last_of_run marks the final result of a request and string_done
// the final result of a request carrying end_of_string. A decode sequence cut
// short by end_of_string yields one unit with truncated set, missing bits zero.
// Rate: the front takes one request per cycle into a four-entry queue while it
// has room; the back drains one result per cycle unless dst_stall holds it; an
// encode request yields one to three results (its byte count) and a decode
// request at most one. A request passes through the queue and then the output
// register before its first result. src_stall rises while the queue is full; a
// stalled result stays in the output register while requests keep being taken.

module modified_utf8_codec_top (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	// request side
	input  logic        src_valid,
	output logic        src_stall,
	input  logic [15:0] in_code_unit,
	input  logic [7:0]  in_byte,
	input  logic        end_of_string,
	// result side
	output logic        dst_valid,
	input  logic        dst_stall,
	output logic [7:0]  out_byte,
	output logic [15:0] out_code_unit,
	output logic        last_of_run,
	output logic        truncated,
	output logic        string_done
);
	import muc_pkg::*;

	logic    accept;
	logic    push;
	cmd_t    push_cmd;
	logic    full;
	logic    pop;
	q_head_t head;

	// take a request whenever the queue has room
	assign src_stall = full;
	assign accept    = src_valid && !full;

	// Front: direction register, encoder, decoder state; classify and push.
	muc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.accept       (accept),
		.in_code_unit (in_code_unit),
		.in_byte      (in_byte),
		.end_of_string(end_of_string),
		.push         (push),
		.push_cmd     (push_cmd)
	);

	// Queue: decouples request intake from result delivery.
	muc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.pop     (pop),
		.full    (full),
		.head    (head)
	);

	// Back: step through the head request, one result per cycle unless stalled.
	muc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.pop          (pop),
		.dst_stall    (dst_stall),
		.dst_valid    (dst_valid),
		.out_byte     (out_byte),
		.out_code_unit(out_code_unit),
		.last_of_run  (last_of_run),
		.truncated    (truncated),
		.string_done  (string_done)
	);

endmodule

@@ design/muc_checker.sv @@
`timescale 1ns / 1ps

module muc_port_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        dst_valid,
	input logic        dst_stall,
	input logic [7:0]  out_byte,
	input logic [15:0] out_code_unit,
	input logic        last_of_run,
	input logic        truncated,
	input logic        string_done
);

	// a stalled result stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_stall |=> dst_valid)
		else $error("result dropped while stalled");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && string_done |-> last_of_run)
		else $error("string_done without last_of_run");

	a_trunc: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && truncated |-> string_done && last_of_run && out_byte == 8'd0)
		else $error("truncated result malformed");

	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && out_byte != 8'd0 |-> out_code_unit == 16'd0)
		else $error("byte and unit both set");

endmodule

bind modified_utf8_codec_top muc_port_checker u_muc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.dst_valid    (dst_valid),
	.dst_stall    (dst_stall),
	.out_byte     (out_byte),
	.out_code_unit(out_code_unit),
	.last_of_run  (last_of_run),
	.truncated    (truncated),
	.string_done  (string_done)
);
